// ===== hw/rtl/fct_pkg.sv =====
// Shared types, constants and helpers of the cluster allocation table engine.
package fct_pkg;

  localparam int MAX_TABLE_SECTORS  = 32;
  localparam int ENTRIES_PER_SECTOR = 128;
  localparam int TABLE_DEPTH        = MAX_TABLE_SECTORS * ENTRIES_PER_SECTOR;
  localparam int ADDR_W             = $clog2(TABLE_DEPTH);
  localparam int LIM_W              = ADDR_W + 1;
  localparam int SECT_SHIFT         = $clog2(ENTRIES_PER_SECTOR);
  localparam int LINK_W             = 28;
  localparam int ENTRY_W            = 32;
  localparam int TS_W               = 6;
  localparam int CMD_W              = 2;
  localparam int STATUS_W           = 3;
  localparam int RES_CL_W           = 12;

  localparam logic [TS_W-1:0]   TS_RESET = TS_W'(32);
  localparam logic [LINK_W-1:0] END_MARK = 28'hFFFFFFF;

  localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOW    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BOUNDS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CHAIN  = 3'd4;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [LINK_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   cluster;
    logic [LINK_W-1:0]   value;
  } res_t;

  function automatic logic [STATUS_W-1:0] check_cluster(
    input logic [LINK_W-1:0] cl,
    input logic [LIM_W-1:0]  lim
  );
    logic [STATUS_W-1:0] st;
    st = ST_OK;
    if (cl < LINK_W'(2)) begin
      st = ST_LOW;
    end else if (cl >= LINK_W'(lim)) begin
      st = ST_BOUNDS;
    end
    return st;
  endfunction

endpackage

// ===== hw/rtl/fct_link_ram.sv =====
// Single-port link table memory with a registered read.
module fct_link_ram (
  input  logic                          clk_i,
  input  fct_pkg::mem_req_t             req_i,
  output logic [fct_pkg::LINK_W-1:0]    rdata_o
);

  logic [fct_pkg::LINK_W-1:0] mem [fct_pkg::TABLE_DEPTH];
  logic [fct_pkg::LINK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fct_ctrl.sv =====
// Command sequencer that reads, modifies and writes back the link table.
module fct_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fct_pkg::CMD_W-1:0]     command_i,
  input  logic [fct_pkg::LINK_W-1:0]    cluster_i,
  input  logic [fct_pkg::LINK_W-1:0]    next_value_i,
  input  logic [fct_pkg::LIM_W-1:0]     lim_i,
  input  logic                          out_free_i,
  output logic                          out_load_o,
  output fct_pkg::res_t                 res_o,
  output fct_pkg::mem_req_t             mem_req_o,
  input  logic [fct_pkg::LINK_W-1:0]    mem_rdata_i
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_ALLOC     = 4'd2;
  localparam logic [3:0] S_FREE_CHK  = 4'd3;
  localparam logic [3:0] S_FREE_DATA = 4'd4;
  localparam logic [3:0] S_READ_DATA = 4'd5;
  localparam logic [3:0] S_RESP      = 4'd6;

  logic [3:0]                   state_q, state_d;
  logic [fct_pkg::ADDR_W-1:0]   idx_q, idx_d;
  logic [fct_pkg::LINK_W-1:0]   cur_q, cur_d;
  fct_pkg::res_t                res_q, res_d;
  logic [fct_pkg::STATUS_W-1:0] chk;
  logic [fct_pkg::LIM_W-1:0]    idx_next;

  assign in_ready_o = (state_q == S_IDLE);
  assign res_o      = res_q;
  assign idx_next   = fct_pkg::LIM_W'(idx_q) + fct_pkg::LIM_W'(1);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cur_d      = cur_q;
    res_d      = res_q;
    out_load_o = 1'b0;
    mem_req_o  = '0;
    chk        = fct_pkg::ST_OK;
    case (state_q)
      S_CLEAR: begin
        mem_req_o.we   = 1'b1;
        mem_req_o.addr = idx_q;
        idx_d          = fct_pkg::ADDR_W'(idx_next);
        if (idx_q == fct_pkg::ADDR_W'(fct_pkg::TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          cur_d = cluster_i;
          chk   = fct_pkg::check_cluster(cluster_i, lim_i);
          case (command_i)
            fct_pkg::CMD_SET: begin
              res_d.status = chk;
              if (chk == fct_pkg::ST_OK) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.addr  = cluster_i[fct_pkg::ADDR_W-1:0];
                mem_req_o.wdata = next_value_i;
              end
              state_d = S_RESP;
            end
            fct_pkg::CMD_ALLOC: begin
              if (lim_i <= fct_pkg::LIM_W'(2)) begin
                res_d.status = fct_pkg::ST_FULL;
                state_d      = S_RESP;
              end else begin
                mem_req_o.re   = 1'b1;
                mem_req_o.addr = fct_pkg::ADDR_W'(2);
                idx_d          = fct_pkg::ADDR_W'(2);
                state_d        = S_ALLOC;
              end
            end
            fct_pkg::CMD_FREE: begin
              state_d = S_FREE_CHK;
            end
            default: begin
              res_d.status = chk;
              if (chk == fct_pkg::ST_OK) begin
                mem_req_o.re   = 1'b1;
                mem_req_o.addr = cluster_i[fct_pkg::ADDR_W-1:0];
                state_d        = S_READ_DATA;
              end else begin
                state_d = S_RESP;
              end
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (mem_rdata_i == '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = idx_q;
          mem_req_o.wdata = fct_pkg::END_MARK;
          res_d.status    = fct_pkg::ST_OK;
          res_d.cluster   = idx_q;
          state_d         = S_RESP;
        end else if (idx_next >= lim_i) begin
          res_d.status = fct_pkg::ST_FULL;
          state_d      = S_RESP;
        end else begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = fct_pkg::ADDR_W'(idx_next);
          idx_d          = fct_pkg::ADDR_W'(idx_next);
        end
      end
      S_FREE_CHK: begin
        chk = fct_pkg::check_cluster(cur_q, lim_i);
        if (cur_q == '0 || cur_q == fct_pkg::END_MARK) begin
          res_d.status = fct_pkg::ST_OK;
          state_d      = S_RESP;
        end else if (chk == fct_pkg::ST_LOW) begin
          res_d.status = fct_pkg::ST_LOW;
          state_d      = S_RESP;
        end else if (chk == fct_pkg::ST_BOUNDS) begin
          res_d.status = fct_pkg::ST_CHAIN;
          state_d      = S_RESP;
        end else begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = cur_q[fct_pkg::ADDR_W-1:0];
          state_d        = S_FREE_DATA;
        end
      end
      S_FREE_DATA: begin
        mem_req_o.we   = 1'b1;
        mem_req_o.addr = cur_q[fct_pkg::ADDR_W-1:0];
        cur_d          = mem_rdata_i;
        state_d        = S_FREE_CHK;
      end
      S_READ_DATA: begin
        res_d.value = mem_rdata_i;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

endmodule

// ===== hw/rtl/fat32_cluster_table_engine.sv =====
// Top level of the cluster allocation table engine.
// After reset the block sweeps its 4096-entry link memory to zero, one entry per
// cycle, and takes no item until the sweep is done; configuration writes are
// accepted at any time. Items are then handled one at a time by a sequencer
// around the single-port link memory, whose registered read sets the pace: set
// link writes the entry if the cluster is valid, read entry reads it and returns
// its value, free chain reads and clears each link in turn, and allocate scans
// from cluster 2 upward for a zero entry and marks it as the end of a chain. A
// result waits in an output register, and the next item is taken while it is
// held.
module fat32_cluster_table_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fct_pkg::TS_W-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fct_pkg::CMD_W-1:0]         command_i,
  input  logic [fct_pkg::LINK_W-1:0]        cluster_i,
  input  logic [fct_pkg::LINK_W-1:0]        next_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fct_pkg::STATUS_W-1:0]      status_o,
  output logic [fct_pkg::RES_CL_W-1:0]      result_cluster_o,
  output logic [fct_pkg::ENTRY_W-1:0]       entry_value_o
);

  logic [fct_pkg::TS_W-1:0]  table_sectors_q;
  logic [fct_pkg::LIM_W-1:0] lim;
  logic                      out_valid_q;
  logic                      out_free;
  logic                      out_load;
  fct_pkg::res_t             res;
  fct_pkg::res_t             out_q;
  fct_pkg::mem_req_t         mem_req;
  logic [fct_pkg::LINK_W-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_sectors_q <= fct_pkg::TS_RESET;
    end else if (cfg_valid_i) begin
      table_sectors_q <= cfg_data_i;
    end
  end

  // Oversized settings are clamped to the full table.
  always_comb begin
    if (fct_pkg::LIM_W'(table_sectors_q) > fct_pkg::LIM_W'(fct_pkg::MAX_TABLE_SECTORS)) begin
      lim = fct_pkg::LIM_W'(fct_pkg::TABLE_DEPTH);
    end else begin
      lim = fct_pkg::LIM_W'(fct_pkg::LIM_W'(table_sectors_q) << fct_pkg::SECT_SHIFT);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  fct_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .cluster_i    (cluster_i),
    .next_value_i (next_value_i),
    .lim_i        (lim),
    .out_free_i   (out_free),
    .out_load_o   (out_load),
    .res_o        (res),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  fct_link_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign result_cluster_o = fct_pkg::RES_CL_W'(out_q.cluster);
  assign entry_value_o    = fct_pkg::ENTRY_W'(out_q.value);

endmodule
